[rtl/tae_pkg.sv]
// shared types and codes of the thumb alu execute block
package tae_pkg;

  localparam int unsigned RegAddrW = 4;
  localparam int unsigned RegCount = 15;
  localparam logic [RegAddrW-1:0] PcIndex = 4'd15;

  localparam logic [1:0] ActExec     = 2'd0;
  localparam logic [1:0] ActLoadReg  = 2'd1;
  localparam logic [1:0] ActLoadFlag = 2'd2;

  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatUndef = 2'd1;
  localparam logic [1:0] StatOther = 2'd2;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [31:0]         data;
  } reg_wr_t;

  typedef struct packed {
    logic [31:0]         result;
    logic [RegAddrW-1:0] didx;
    logic                wr;
    logic [3:0]          flags;
    logic                tbit;
    logic                br;
    logic [31:0]         tgt;
    logic [1:0]          status;
  } exec_t;

endpackage

[rtl/tae_regs.sv]
// register file r0 to r14 with registered, bypassed reads and reset valid bits
module tae_regs import tae_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [RegAddrW-1:0] raddr0,
  input  logic [RegAddrW-1:0] raddr1,
  input  reg_wr_t             wr,
  output logic [31:0]         rdata0,
  output logic [31:0]         rdata1
);

  logic [31:0]         mem [0:RegCount-1];
  logic [RegCount-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr != PcIndex) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en && wr.addr != PcIndex) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == raddr0) begin
        rdata0 <= wr.data;
      end else if (raddr0 != PcIndex && valid[raddr0]) begin
        rdata0 <= mem[raddr0];
      end else begin
        rdata0 <= '0;
      end
      if (wr.en && wr.addr == raddr1) begin
        rdata1 <= wr.data;
      end else if (raddr1 != PcIndex && valid[raddr1]) begin
        rdata1 <= mem[raddr1];
      end else begin
        rdata1 <= '0;
      end
    end
  end

endmodule

[rtl/tae_alu.sv]
// decode, barrel shifter, adder, multiplier and flag logic of one instruction
module tae_alu import tae_pkg::*; (
  input  logic [1:0]          act,
  input  logic [15:0]         ins,
  input  logic [RegAddrW-1:0] lidx,
  input  logic [31:0]         lval,
  input  logic [31:0]         op0,
  input  logic [31:0]         op1,
  input  logic [3:0]          flags,
  input  logic                tbit,
  output exec_t               ex
);

  function automatic logic [32:0] shift(input logic [31:0] x, input logic [1:0] typ,
                                        input logic [7:0] amt, input logic cin);
    logic [32:0] t;
    logic [63:0] w;
    t = {cin, x};
    w = '0;
    if (amt != 8'd0) begin
      case (typ)
        2'd0: begin
          if (amt < 8'd32) begin
            t = {1'b0, x} << amt[4:0];
          end else begin
            t = {(amt == 8'd32) ? x[0] : 1'b0, 32'd0};
          end
        end
        2'd1: begin
          if (amt < 8'd32) begin
            w = {x, 32'd0} >> amt[4:0];
            t = {w[31], w[63:32]};
          end else begin
            t = {(amt == 8'd32) ? x[31] : 1'b0, 32'd0};
          end
        end
        2'd2: begin
          if (amt < 8'd32) begin
            w = $signed({x, 32'd0}) >>> amt[4:0];
            t = {w[31], w[63:32]};
          end else begin
            t = {x[31], {32{x[31]}}};
          end
        end
        default: begin
          w = {x, x} >> amt[4:0];
          t = {w[31], w[31:0]};
        end
      endcase
    end
    return t;
  endfunction

  function automatic logic [33:0] add(input logic [31:0] a, input logic [31:0] b,
                                      input logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    return {s[32], (~(a[31] ^ b[31])) & (a[31] ^ s[31]), s[31:0]};
  endfunction

  logic [32:0] sh;
  logic [33:0] sm;
  logic [31:0] prod;
  logic [31:0] r;
  logic        c;
  logic        v;
  logic        setf;
  logic [4:0]  off;
  logic [31:0] b2;

  assign prod = op1 * op0;
  assign off  = ins[10:6];
  assign b2   = ins[10] ? {29'd0, ins[8:6]} : op1;

  always_comb begin
    ex        = '0;
    ex.flags  = flags;
    ex.tbit   = tbit;
    r         = '0;
    c         = flags[1];
    v         = flags[0];
    setf      = 1'b0;
    sh        = '0;
    sm        = '0;
    case (act)
      ActLoadReg: begin
        ex.result = lval;
        ex.didx   = lidx;
        ex.wr     = (lidx != PcIndex);
      end
      ActLoadFlag: begin
        ex.flags = lval[3:0];
        ex.tbit  = lval[4];
      end
      ActExec: begin
        if (ins[15:13] == 3'b000 && ins[12:11] != 2'b11) begin
          sh = shift(op0, ins[12:11],
                     (ins[12:11] != 2'd0 && off == 5'd0) ? 8'd32 : {3'd0, off}, flags[1]);
          r = sh[31:0]; c = sh[32];
          ex.didx = {1'b0, ins[2:0]}; ex.wr = 1'b1; setf = 1'b1;
        end else if (ins[15:11] == 5'b00011) begin
          sm = ins[9] ? add(op0, ~b2, 1'b1) : add(op0, b2, 1'b0);
          r = sm[31:0]; c = sm[33]; v = sm[32];
          ex.didx = {1'b0, ins[2:0]}; ex.wr = 1'b1; setf = 1'b1;
        end else if (ins[15:13] == 3'b001) begin
          ex.didx = {1'b0, ins[10:8]}; setf = 1'b1;
          case (ins[12:11])
            2'd0: r = {24'd0, ins[7:0]};
            2'd2: sm = add(op1, {24'd0, ins[7:0]}, 1'b0);
            default: sm = add(op1, ~{24'd0, ins[7:0]}, 1'b1);
          endcase
          if (ins[12:11] != 2'd0) begin
            r = sm[31:0]; c = sm[33]; v = sm[32];
          end
          ex.wr = (ins[12:11] != 2'd1);
        end else if (ins[15:10] == 6'b010000) begin
          ex.didx = {1'b0, ins[2:0]}; ex.wr = 1'b1; setf = 1'b1;
          case (ins[9:6])
            4'h0: r = op1 & op0;
            4'h1: r = op1 ^ op0;
            4'h2: sh = shift(op1, 2'd0, op0[7:0], flags[1]);
            4'h3: sh = shift(op1, 2'd1, op0[7:0], flags[1]);
            4'h4: sh = shift(op1, 2'd2, op0[7:0], flags[1]);
            4'h5: sm = add(op1, op0, flags[1]);
            4'h6: sm = add(op1, ~op0, flags[1]);
            4'h7: sh = shift(op1, 2'd3, op0[7:0], flags[1]);
            4'h8: begin r = op1 & op0; ex.wr = 1'b0; end
            4'h9: sm = add(32'd0, ~op0, 1'b1);
            4'hA: begin sm = add(op1, ~op0, 1'b1); ex.wr = 1'b0; end
            4'hB: begin sm = add(op1, op0, 1'b0); ex.wr = 1'b0; end
            4'hC: r = op1 | op0;
            4'hD: r = prod;
            4'hE: r = op1 & ~op0;
            default: r = ~op0;
          endcase
          if (ins[9:6] inside {4'h2, 4'h3, 4'h4, 4'h7}) begin
            r = sh[31:0]; c = sh[32];
          end else if (ins[9:6] inside {4'h5, 4'h6, 4'h9, 4'hA, 4'hB}) begin
            r = sm[31:0]; c = sm[33]; v = sm[32];
          end
        end else if (ins[15:10] == 6'b010001) begin
          ex.didx = {ins[7], ins[2:0]};
          case (ins[9:8])
            2'd3: begin
              ex.didx = '0;
              if (ins[7]) begin
                ex.status = StatUndef;
              end else begin
                ex.tbit = op0[0];
                ex.tgt  = op0[0] ? {op0[31:1], 1'b0} : {op0[31:2], 2'b00};
                r       = ex.tgt;
                ex.didx = PcIndex;
                ex.br   = 1'b1;
              end
            end
            2'd1: begin
              sm = add(op1, ~op0, 1'b1);
              r = sm[31:0]; c = sm[33]; v = sm[32]; setf = 1'b1;
            end
            default: begin
              r = (ins[9:8] == 2'd0) ? op1 + op0 : op0;
              if (ex.didx == PcIndex) begin
                ex.br  = 1'b1;
                ex.tgt = {r[31:1], 1'b0};
              end else begin
                ex.wr = 1'b1;
              end
            end
          endcase
        end else begin
          ex.status = StatOther;
        end
        if (setf) begin
          ex.flags = {r[31], r == 32'd0, c, v};
        end
        ex.result = r;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/thumb_alu_execute.sv]
// top level of the thumb data-processing execute block
//
// input channel s_axis: one word per instruction or load, action in tuser.
// output channel m_axis: one result word per input word, status in tuser.
// a word is accepted at an edge with tvalid and tready both high.
// the word is captured together with its registered register-file reads,
// then executed in one pass (shifter, adder or 32x32 multiplier) into the
// output register. throughput is one word per cycle while m_axis_tready
// is high; register writes are bypassed into the reads of the word accepted
// at the same edge, so no bubbles are needed.
// while m_axis_tready is low the result holds, the captured word waits, and
// s_axis_tready drops once both stages are full.
// reset clears r0 to r14 to zero through per-register valid bits, clears
// nzcv, sets the t bit and empties both stages; words are taken right away.
module thumb_alu_execute import tae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instruction[15:0], pc_plus4[47:16], load_index[51:48], load_value[83:52]
  input  logic [87:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value[31:0], dest_index[35:32], dest_written[36], flags_nzcv[40:37],
  // thumb_state[41], branch_taken[42], branch_target[74:43]
  output logic [79:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  logic                in_valid;
  logic [1:0]          act;
  logic [15:0]         ins;
  logic [31:0]         pc;
  logic [RegAddrW-1:0] lidx;
  logic [31:0]         lval;
  logic                pc0;
  logic                pc1;
  logic [3:0]          flags;
  logic                tbit;
  logic                advance;
  logic                accept;
  logic [15:0]         new_ins;
  logic                new_hi;
  logic [RegAddrW-1:0] raddr0;
  logic [RegAddrW-1:0] raddr1;
  logic [31:0]         rdata0;
  logic [31:0]         rdata1;
  logic [31:0]         op0;
  logic [31:0]         op1;
  exec_t               ex;
  exec_t               res;
  reg_wr_t             wr;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign new_ins = s_axis_tdata[15:0];
  assign new_hi  = (new_ins[15:10] == 6'b010001);

  always_comb begin
    raddr0 = {new_hi & new_ins[6], new_ins[5:3]};
    case (new_ins[15:13])
      3'b000:  raddr1 = {1'b0, new_ins[8:6]};
      3'b001:  raddr1 = {1'b0, new_ins[10:8]};
      default: raddr1 = {new_hi & new_ins[7], new_ins[2:0]};
    endcase
  end

  assign wr.en   = advance && ex.wr;
  assign wr.addr = ex.didx;
  assign wr.data = ex.result;

  tae_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .wr     (wr),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= s_axis_tuser;
      ins  <= new_ins;
      pc   <= s_axis_tdata[47:16];
      lidx <= s_axis_tdata[51:48];
      lval <= s_axis_tdata[83:52];
      pc0  <= (raddr0 == PcIndex);
      pc1  <= (raddr1 == PcIndex);
    end
  end

  assign op0 = pc0 ? pc : rdata0;
  assign op1 = pc1 ? pc : rdata1;

  tae_alu u_alu (
    .act   (act),
    .ins   (ins),
    .lidx  (lidx),
    .lval  (lval),
    .op0   (op0),
    .op1   (op1),
    .flags (flags),
    .tbit  (tbit),
    .ex    (ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= 4'd0;
      tbit          <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        flags         <= ex.flags;
        tbit          <= ex.tbit;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= ex;
    end
  end

  assign m_axis_tdata = {5'd0, res.tgt, res.br, res.tbit, res.flags, res.wr,
                         res.didx, res.result};
  assign m_axis_tuser = res.status;

endmodule
